// ===== sv/sal_pkg.sv =====
// Shared types, codes and constants of the suffix array and LCP builder.
package sal_pkg;

	localparam int MAX_LEN_DEF = 4096;
	localparam logic [8:0] ALPHA_RESET = 9'd32;
	localparam logic [8:0] ALPHA_CAP = 9'd256;

	typedef logic [1:0]  func_t;
	typedef logic [7:0]  sym_t;
	typedef logic [12:0] rank_t;
	typedef logic [1:0]  kind_t;
	typedef logic [11:0] pos_t;
	typedef logic [12:0] len_t;
	typedef logic [8:0]  alpha_t;

	localparam func_t FUNC_LOAD  = 2'd0;
	localparam func_t FUNC_READ  = 2'd1;
	localparam func_t FUNC_CLEAR = 2'd2;

	localparam kind_t KIND_DONE  = 2'd0;
	localparam kind_t KIND_READ  = 2'd1;
	localparam kind_t KIND_ERROR = 2'd2;

	typedef enum logic [2:0] {
		DEC_LOAD,
		DEC_BUILD,
		DEC_READ,
		DEC_CLEAR,
		DEC_ERR
	} dec_t;

	typedef enum logic [5:0] {
		S_IDLE, S_RD_ADDR, S_RD_CAP, S_EMIT,
		S_B_INIT, S_CP_RD, S_CP_WR,
		S_BP_CLR, S_BP_CA, S_BP_CB, S_BP_CC, S_BP_CD,
		S_PF_A, S_PF_B,
		S_PL_A, S_PL_B, S_PL_C, S_PL_D,
		S_DT_SET, S_DT, S_DS_A, S_DS_B,
		S_SWAP, S_RK_S, S_RK_Y1, S_RK_Y2, S_RK_W, S_CHK,
		S_KA_A, S_KA_B,
		S_KB_R, S_KB_J, S_KB_J2, S_KB_T1, S_KB_T2, S_KB_T3, S_KB_WR,
		S_DONE
	} state_t;

	typedef enum logic [5:0] {
		C_IDLE, C_RD_ADDR, C_RD_CAP, C_EMIT,
		C_B_INIT, C_CP_RD, C_CP_WR,
		C_BP_CLR, C_BP_CA, C_BP_CB, C_BP_CC, C_BP_CD,
		C_PF_A, C_PF_B,
		C_PL_A, C_PL_B, C_PL_C, C_PL_D,
		C_DT_SET, C_DT, C_DS_A, C_DS_B,
		C_SWAP, C_RK_S, C_RK_Y1, C_RK_Y2, C_RK_W, C_CHK,
		C_KA_A, C_KA_B,
		C_KB_R, C_KB_J, C_KB_J2, C_KB_T1, C_KB_T2, C_KB_T3, C_KB_WR,
		C_DONE
	} cmd_t;

	typedef struct packed {
		logic fire;
		dec_t dec;
		logic last_it;
		logic slot_free;
		logic cmp_go;
		logic t_eq;
		logic brk;
	} status_t;

endpackage

// ===== sv/sal_req_if.sv =====
// Request channel: valid/ready handshake with the request fields.
interface sal_req_if;
	import sal_pkg::*;
	logic  valid;
	logic  ready;
	func_t func;
	sym_t  symbol;
	logic  last;
	rank_t rank;
	modport source (output valid, func, symbol, last, rank, input ready);
	modport sink (input valid, func, symbol, last, rank, output ready);
endinterface

// ===== sv/sal_rsp_if.sv =====
// Result channel: valid/ready handshake with the result fields.
interface sal_rsp_if;
	import sal_pkg::*;
	logic  valid;
	logic  ready;
	kind_t kind;
	pos_t  suffix_pos;
	pos_t  lcp;
	len_t  length;
	modport source (output valid, kind, suffix_pos, lcp, length, input ready);
	modport sink (input valid, kind, suffix_pos, lcp, length, output ready);
endinterface

// ===== sv/sal_cfg_if.sv =====
// Configuration write channel carrying the alphabet size.
interface sal_cfg_if;
	import sal_pkg::*;
	logic   valid;
	logic   ready;
	alpha_t data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== sv/sal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/sal_ctrl.sv =====
// Sequencer for load, read, build (prefix doubling) and LCP passes.
module sal_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  sal_pkg::status_t st,
	output sal_pkg::cmd_t    cmd
);
	import sal_pkg::*;

	state_t state_q, state_d;
	logic   first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_B_INIT) begin
				first_q <= 1'b1;
			end else if (state_q == S_DT_SET) begin
				first_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (st.fire) begin
					case (st.dec)
						DEC_LOAD:  state_d = S_IDLE;
						DEC_CLEAR: state_d = S_IDLE;
						DEC_BUILD: state_d = S_B_INIT;
						DEC_READ:  state_d = S_RD_ADDR;
						default:   state_d = S_EMIT;
					endcase
				end
			end
			S_RD_ADDR: state_d = S_RD_CAP;
			S_RD_CAP:  state_d = S_EMIT;
			S_EMIT:    state_d = st.slot_free ? S_IDLE : S_EMIT;
			S_B_INIT:  state_d = S_CP_RD;
			S_CP_RD:   state_d = S_CP_WR;
			S_CP_WR:   state_d = st.last_it ? S_BP_CLR : S_CP_RD;
			S_BP_CLR:  state_d = st.last_it ? S_BP_CA : S_BP_CLR;
			S_BP_CA:   state_d = S_BP_CB;
			S_BP_CB:   state_d = S_BP_CC;
			S_BP_CC:   state_d = S_BP_CD;
			S_BP_CD:   state_d = st.last_it ? S_PF_A : S_BP_CA;
			S_PF_A:    state_d = S_PF_B;
			S_PF_B:    state_d = st.last_it ? S_PL_A : S_PF_A;
			S_PL_A:    state_d = S_PL_B;
			S_PL_B:    state_d = S_PL_C;
			S_PL_C:    state_d = S_PL_D;
			S_PL_D: begin
				if (st.last_it) begin
					state_d = first_q ? S_DT_SET : S_SWAP;
				end else begin
					state_d = S_PL_A;
				end
			end
			S_DT_SET:  state_d = S_DT;
			S_DT:      state_d = st.last_it ? S_DS_A : S_DT;
			S_DS_A:    state_d = S_DS_B;
			S_DS_B:    state_d = st.last_it ? S_BP_CLR : S_DS_A;
			S_SWAP:    state_d = S_RK_S;
			S_RK_S:    state_d = S_RK_Y1;
			S_RK_Y1:   state_d = S_RK_Y2;
			S_RK_Y2:   state_d = S_RK_W;
			S_RK_W:    state_d = st.last_it ? S_CHK : S_RK_S;
			S_CHK:     state_d = st.brk ? S_KA_A : S_DT_SET;
			S_KA_A:    state_d = S_KA_B;
			S_KA_B:    state_d = st.last_it ? S_KB_R : S_KA_A;
			S_KB_R:    state_d = S_KB_J;
			S_KB_J:    state_d = S_KB_J2;
			S_KB_J2:   state_d = S_KB_T1;
			S_KB_T1:   state_d = st.cmp_go ? S_KB_T2 : S_KB_WR;
			S_KB_T2:   state_d = S_KB_T3;
			S_KB_T3:   state_d = st.t_eq ? S_KB_T1 : S_KB_WR;
			S_KB_WR:   state_d = st.last_it ? S_DONE : S_KB_R;
			S_DONE:    state_d = S_EMIT;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			S_IDLE:    cmd = C_IDLE;
			S_RD_ADDR: cmd = C_RD_ADDR;
			S_RD_CAP:  cmd = C_RD_CAP;
			S_EMIT:    cmd = C_EMIT;
			S_B_INIT:  cmd = C_B_INIT;
			S_CP_RD:   cmd = C_CP_RD;
			S_CP_WR:   cmd = C_CP_WR;
			S_BP_CLR:  cmd = C_BP_CLR;
			S_BP_CA:   cmd = C_BP_CA;
			S_BP_CB:   cmd = C_BP_CB;
			S_BP_CC:   cmd = C_BP_CC;
			S_BP_CD:   cmd = C_BP_CD;
			S_PF_A:    cmd = C_PF_A;
			S_PF_B:    cmd = C_PF_B;
			S_PL_A:    cmd = C_PL_A;
			S_PL_B:    cmd = C_PL_B;
			S_PL_C:    cmd = C_PL_C;
			S_PL_D:    cmd = C_PL_D;
			S_DT_SET:  cmd = C_DT_SET;
			S_DT:      cmd = C_DT;
			S_DS_A:    cmd = C_DS_A;
			S_DS_B:    cmd = C_DS_B;
			S_SWAP:    cmd = C_SWAP;
			S_RK_S:    cmd = C_RK_S;
			S_RK_Y1:   cmd = C_RK_Y1;
			S_RK_Y2:   cmd = C_RK_Y2;
			S_RK_W:    cmd = C_RK_W;
			S_CHK:     cmd = C_CHK;
			S_KA_A:    cmd = C_KA_A;
			S_KA_B:    cmd = C_KA_B;
			S_KB_R:    cmd = C_KB_R;
			S_KB_J:    cmd = C_KB_J;
			S_KB_J2:   cmd = C_KB_J2;
			S_KB_T1:   cmd = C_KB_T1;
			S_KB_T2:   cmd = C_KB_T2;
			S_KB_T3:   cmd = C_KB_T3;
			S_KB_WR:   cmd = C_KB_WR;
			S_DONE:    cmd = C_DONE;
			default:   cmd = C_IDLE;
		endcase
	end
endmodule

// ===== sv/sal_dp.sv =====
// Datapath: work memories, loop counters, request decode and result register.
module sal_dp #(
	parameter int MAX_LEN = sal_pkg::MAX_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	sal_cfg_if.sink          cfg,
	sal_req_if.sink          req,
	sal_rsp_if.source        rsp,
	input  sal_pkg::cmd_t    cmd,
	output sal_pkg::status_t st
);
	import sal_pkg::*;

	localparam int DEPTH = MAX_LEN + 1;
	localparam int MAW   = $clog2(DEPTH);
	localparam int AW    = $clog2(MAX_LEN + 2);
	localparam int VW    = (AW > 8) ? AW : 8;
	localparam int BD    = (DEPTH > 256) ? DEPTH : 256;
	localparam int BAW   = $clog2(BD);
	localparam int IW    = $clog2(BD + 1);
	localparam int CW    = (AW > 13) ? AW : 13;

	// control state
	logic [AW-1:0] n_q;
	logic          built_q;
	alpha_t        alpha_q;
	logic          out_valid_q;

	// loop and work registers
	logic [IW-1:0]  i_q;
	logic [IW-1:0]  m_q;
	logic [AW:0]    k_q;
	logic [AW-1:0]  p_q;
	logic [AW-1:0]  h_q;
	logic [AW-1:0]  acc_q;
	logic [VW-1:0]  key_q;
	logic [AW-1:0]  s_q;
	logic [AW-1:0]  b_q;
	logic [VW-1:0]  ya_q, yb_q, yak_q;
	logic           ain_q, bk_in_q;
	logic [AW-1:0]  r_q, j_q;
	logic [7:0]     t1_q;
	logic           xsel_q;
	logic [MAW-1:0] rd_addr_q;

	kind_t res_kind_q, out_kind_q;
	pos_t  res_pos_q, out_pos_q;
	pos_t  res_lcp_q, out_lcp_q;
	len_t  res_len_q, out_len_q;

	// memory ports
	logic           t_we, s_we, a_we, b_we, c_we, l_we;
	logic [MAW-1:0] t_wa, t_ra, s_wa, s_ra, a_wa, a_ra, b_wa, b_ra, l_wa, l_ra;
	logic [BAW-1:0] c_wa, c_ra;
	logic [7:0]     t_wd, t_rd;
	logic [AW-1:0]  s_wd, s_rd, c_wd, c_rd, l_wd, l_rd;
	logic [VW-1:0]  a_wd, a_rd, b_wd, b_rd;

	// role view of the two rank arrays
	logic           x_we, y_we;
	logic [MAW-1:0] x_wa, y_wa, x_ra, y_ra;
	logic [VW-1:0]  x_wd, y_wd, x_rd, y_rd;

	logic [AW-1:0] cnt;
	logic          fire, slot_free, same, s_ge_k, bad_sym, bad_rank;
	logic [AW:0]   bk_sum, ih_sum, jh_sum;
	dec_t          dec;
	logic          last_it;

	sal_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_text (
		.clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
	sal_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_order (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
	sal_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_rank_a (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
	sal_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_rank_b (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
	sal_ram #(.WIDTH(AW), .DEPTH(BD)) u_bucket (
		.clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
	sal_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_lcp (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));

	assign cnt       = n_q + AW'(1);
	assign fire      = req.valid && (cmd == C_IDLE);
	assign slot_free = !out_valid_q || rsp.ready;
	assign bk_sum    = (AW+1)'(b_q) + k_q;
	assign ih_sum    = (AW+1)'(AW'(i_q)) + (AW+1)'(h_q);
	assign jh_sum    = (AW+1)'(j_q) + (AW+1)'(h_q);
	assign s_ge_k    = (AW+1)'(s_rd) >= k_q;
	assign same      = (ya_q == yb_q) && ain_q && bk_in_q && (yak_q == y_rd);
	assign bad_sym   = (req.symbol == '0) || ({1'b0, req.symbol} >= alpha_q);
	assign bad_rank  = !built_q || (req.rank == '0) || (CW'(req.rank) > CW'(n_q));

	assign x_rd = xsel_q ? b_rd : a_rd;
	assign y_rd = xsel_q ? a_rd : b_rd;

	always_comb begin
		case (req.func)
			FUNC_LOAD: begin
				if (built_q || (n_q >= AW'(MAX_LEN)) || bad_sym) begin
					dec = DEC_ERR;
				end else begin
					dec = req.last ? DEC_BUILD : DEC_LOAD;
				end
			end
			FUNC_READ:  dec = bad_rank ? DEC_ERR : DEC_READ;
			FUNC_CLEAR: dec = DEC_CLEAR;
			default:    dec = DEC_ERR;
		endcase
	end

	always_comb begin
		case (cmd)
			C_CP_WR, C_BP_CD, C_DT, C_DS_B, C_RK_W, C_KA_B: last_it = (i_q == IW'(n_q));
			C_BP_CLR, C_PF_B: last_it = (i_q == m_q - IW'(1));
			C_PL_D:  last_it = (i_q == '0);
			C_KB_WR: last_it = (i_q == IW'(n_q) - IW'(1));
			default: last_it = 1'b0;
		endcase
	end

	always_comb begin
		st.fire      = fire;
		st.dec       = dec;
		st.last_it   = last_it;
		st.slot_free = slot_free;
		st.cmp_go    = (ih_sum < (AW+1)'(n_q)) && (jh_sum < (AW+1)'(n_q));
		st.t_eq      = (t_rd == t1_q);
		st.brk       = (p_q >= cnt) || ((k_q << 1) > (AW+1)'(cnt));
	end

	// memory port steering
	always_comb begin
		t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
		s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
		c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
		l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
		x_we = 1'b0; x_wa = '0; x_wd = '0; x_ra = '0;
		y_we = 1'b0; y_wa = '0; y_wd = '0; y_ra = '0;
		case (cmd)
			C_IDLE: begin
				t_we = fire && ((dec == DEC_LOAD) || (dec == DEC_BUILD));
				t_wa = MAW'(n_q);
				t_wd = req.symbol;
			end
			C_RD_ADDR: begin
				s_ra = rd_addr_q;
				l_ra = rd_addr_q;
			end
			C_B_INIT: begin
				t_we = 1'b1;
				t_wa = MAW'(n_q);
			end
			C_CP_RD: t_ra = MAW'(i_q);
			C_CP_WR: begin
				x_we = 1'b1; x_wa = MAW'(i_q); x_wd = VW'(t_rd);
				y_we = 1'b1; y_wa = MAW'(i_q); y_wd = VW'(i_q);
			end
			C_BP_CLR: begin
				c_we = 1'b1; c_wa = BAW'(i_q);
			end
			C_BP_CA: y_ra = MAW'(i_q);
			C_BP_CB: x_ra = MAW'(y_rd);
			C_BP_CC: c_ra = BAW'(x_rd);
			C_BP_CD: begin
				c_we = 1'b1; c_wa = BAW'(key_q); c_wd = c_rd + AW'(1);
			end
			C_PF_A: c_ra = BAW'(i_q);
			C_PF_B: begin
				c_we = 1'b1; c_wa = BAW'(i_q); c_wd = acc_q + c_rd;
			end
			C_PL_A: y_ra = MAW'(i_q);
			C_PL_B: x_ra = MAW'(y_rd);
			C_PL_C: c_ra = BAW'(x_rd);
			C_PL_D: begin
				c_we = 1'b1; c_wa = BAW'(key_q); c_wd = c_rd - AW'(1);
				s_we = 1'b1; s_wa = MAW'(c_rd - AW'(1)); s_wd = s_q;
			end
			C_DT: begin
				y_we = 1'b1; y_wa = MAW'(p_q); y_wd = VW'(i_q);
			end
			C_DS_A: s_ra = MAW'(i_q);
			C_DS_B: begin
				y_we = s_ge_k; y_wa = MAW'(p_q);
				y_wd = VW'((AW+1)'(s_rd) - k_q);
			end
			C_RK_S:  s_ra = MAW'(i_q);
			C_RK_Y1: y_ra = MAW'(s_rd);
			C_RK_Y2: y_ra = (bk_sum < (AW+1)'(cnt)) ? MAW'(bk_sum) : '0;
			C_RK_W: begin
				x_we = 1'b1; x_wa = MAW'(b_q);
				if (i_q == '0) begin
					x_wd = '0;
				end else begin
					x_wd = same ? VW'(p_q - AW'(1)) : VW'(p_q);
				end
			end
			C_KA_A: s_ra = MAW'(i_q);
			C_KA_B: begin
				// rank of each suffix goes to both arrays whatever the role swap
				x_we = 1'b1; x_wa = MAW'(s_rd); x_wd = VW'(i_q);
				y_we = 1'b1; y_wa = MAW'(s_rd); y_wd = VW'(i_q);
			end
			C_KB_R: begin
				x_ra = MAW'(i_q);
				y_ra = MAW'(i_q);
			end
			C_KB_J:  s_ra = MAW'(a_rd - VW'(1));
			C_KB_T1: t_ra = MAW'(ih_sum);
			C_KB_T2: t_ra = MAW'(jh_sum);
			C_KB_WR: begin
				l_we = 1'b1; l_wa = MAW'(r_q); l_wd = h_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		a_we = xsel_q ? y_we : x_we;
		a_wa = xsel_q ? y_wa : x_wa;
		a_wd = xsel_q ? y_wd : x_wd;
		a_ra = xsel_q ? y_ra : x_ra;
		b_we = xsel_q ? x_we : y_we;
		b_wa = xsel_q ? x_wa : y_wa;
		b_wd = xsel_q ? x_wd : y_wd;
		b_ra = xsel_q ? x_ra : y_ra;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			built_q     <= 1'b0;
			alpha_q     <= ALPHA_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				alpha_q <= cfg.data;
			end
			if (fire) begin
				case (dec)
					DEC_LOAD, DEC_BUILD: n_q <= n_q + AW'(1);
					DEC_CLEAR: begin
						n_q     <= '0;
						built_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd == C_DONE) begin
				built_q <= 1'b1;
			end
			if ((cmd == C_EMIT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			C_IDLE: begin
				if (fire) begin
					rd_addr_q  <= MAW'(CW'(req.rank));
					res_kind_q <= KIND_ERROR;
					res_pos_q  <= '0;
					res_lcp_q  <= '0;
					res_len_q  <= '0;
				end
			end
			C_RD_CAP: begin
				res_kind_q <= KIND_READ;
				res_pos_q  <= pos_t'(s_rd);
				res_lcp_q  <= pos_t'(l_rd);
				res_len_q  <= len_t'(n_q);
			end
			C_DONE: begin
				res_kind_q <= KIND_DONE;
				res_pos_q  <= '0;
				res_lcp_q  <= '0;
				res_len_q  <= len_t'(n_q);
			end
			C_EMIT: begin
				if (slot_free) begin
					out_kind_q <= res_kind_q;
					out_pos_q  <= res_pos_q;
					out_lcp_q  <= res_lcp_q;
					out_len_q  <= res_len_q;
				end
			end
			C_B_INIT: begin
				i_q    <= '0;
				k_q    <= (AW+1)'(1);
				xsel_q <= 1'b0;
				m_q    <= (alpha_q > ALPHA_CAP) ? IW'(ALPHA_CAP) : IW'(alpha_q);
			end
			C_CP_WR, C_BP_CLR, C_RK_W: i_q <= last_it ? '0 : i_q + IW'(1);
			C_BP_CC, C_PL_C: key_q <= x_rd;
			C_BP_CD: begin
				i_q   <= last_it ? '0 : i_q + IW'(1);
				acc_q <= '0;
			end
			C_PF_B: begin
				acc_q <= acc_q + c_rd;
				i_q   <= last_it ? IW'(n_q) : i_q + IW'(1);
			end
			C_PL_B: s_q <= AW'(y_rd);
			C_PL_D: i_q <= last_it ? '0 : i_q - IW'(1);
			C_DT_SET: begin
				p_q <= '0;
				i_q <= IW'((AW+1)'(cnt) - k_q);
			end
			C_DT: begin
				p_q <= p_q + AW'(1);
				i_q <= last_it ? '0 : i_q + IW'(1);
			end
			C_DS_B: begin
				if (s_ge_k) begin
					p_q <= p_q + AW'(1);
				end
				i_q <= last_it ? '0 : i_q + IW'(1);
			end
			C_SWAP: begin
				xsel_q <= !xsel_q;
				p_q    <= AW'(1);
				i_q    <= '0;
			end
			C_RK_Y1: b_q <= s_rd;
			C_RK_Y2: begin
				yb_q    <= y_rd;
				bk_in_q <= bk_sum < (AW+1)'(cnt);
			end
			C_CHK: begin
				m_q <= IW'(p_q);
				k_q <= k_q << 1;
				i_q <= IW'(1);
			end
			C_KA_B: begin
				i_q <= last_it ? '0 : i_q + IW'(1);
				h_q <= '0;
			end
			C_KB_J: begin
				r_q <= AW'(a_rd);
				if (h_q != '0) begin
					h_q <= h_q - AW'(1);
				end
			end
			C_KB_J2: j_q <= s_rd;
			C_KB_T2: t1_q <= t_rd;
			C_KB_T3: begin
				if (t_rd == t1_q) begin
					h_q <= h_q + AW'(1);
				end
			end
			C_KB_WR: i_q <= last_it ? '0 : i_q + IW'(1);
			default: ;
		endcase
		// slide the current pair to the previous one for the next compare
		if (cmd == C_RK_W) begin
			if (i_q != '0 && !same) begin
				p_q <= p_q + AW'(1);
			end
			ya_q  <= yb_q;
			yak_q <= y_rd;
			ain_q <= bk_in_q;
		end
	end

	assign req.ready      = (cmd == C_IDLE);
	assign cfg.ready      = 1'b1;
	assign rsp.valid      = out_valid_q;
	assign rsp.kind       = out_kind_q;
	assign rsp.suffix_pos = out_pos_q;
	assign rsp.lcp        = out_lcp_q;
	assign rsp.length     = out_len_q;
endmodule

// ===== sv/suffix_array_lcp_builder.sv =====
// Top level of the suffix array and LCP builder: sequencer plus datapath.
// Usage:
//   req  : requests (func, symbol, last, rank). func load appends one symbol;
//          a load with last set starts the build. func read returns the suffix
//          start and LCP at a rank. func clear drops the text.
//   rsp  : results (kind, suffix_pos, lcp, length) through a one-entry output
//          register; a request is taken while an older result still waits.
//   cfg  : alphabet size write, always ready; write it only while nothing is in flight.
// Steps:
//   A load without last or a clear gives no result; an error goes straight
//   to the emit step, a read through address and capture steps to it.
//   The build runs on single-write, single-read RAMs with registered reads,
//   so every memory access is its own step: a text copy, then a counting pass,
//   each doubling round a rank pass plus one counting pass, and the LCP
//   sweep (at most 2n matched symbols).
// Reset: clears length, built flag and the output slot, sets alphabet size to 32;
//   the work memories are not cleared and hold nothing of use until a build.
// Stall: when rsp is not ready the result holds; the next request that makes
//   a result waits in the emit step until the slot frees; requests wait meanwhile.
module suffix_array_lcp_builder #(
	parameter int MAX_LEN = sal_pkg::MAX_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sal_cfg_if.sink   cfg,
	sal_req_if.sink   req,
	sal_rsp_if.source rsp
);
	import sal_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencer: steps through load, read and build passes
	sal_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.st(st),
		.cmd(cmd)
	);

	// datapath: memories, counters, decode and output register
	sal_dp #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.rsp(rsp),
		.cmd(cmd),
		.st(st)
	);

`ifndef SYNTH
	// a build-done result carries no position or lcp
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == KIND_DONE |-> rsp.suffix_pos == '0 && rsp.lcp == '0)
		else $error("done result with nonzero payload");

	// an error result has zero length and lcp
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == KIND_ERROR |-> rsp.length == '0 && rsp.lcp == '0)
		else $error("error result with nonzero payload");

	// a read only succeeds on a nonempty built text
	a_read_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == KIND_READ |-> rsp.length != '0)
		else $error("read result with zero length");

	// a clear finishes at once and the block takes the next request
	a_clear_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.func == FUNC_CLEAR |=> req.ready)
		else $error("clear did not return to idle");
`endif
endmodule

// ===== sim/suffix_array_lcp_builder_test.sv =====
// Self-checking testbench of the suffix array and LCP builder.
module suffix_array_lcp_builder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sal_pkg::*;

	localparam int IDLE_LIMIT  = 300000;
	localparam int SETTLE_CYC  = 50;
	localparam int RANDOM_ITEMS = 1050;

	typedef struct packed {
		func_t func;
		sym_t  symbol;
		logic  last;
		rank_t rank;
	} request_t;

	typedef struct packed {
		kind_t kind;
		pos_t  suffix_pos;
		pos_t  lcp;
		len_t  length;
	} result_t;

	// Tracks text, suffix order and LCP table, and holds results still owed.
	class lcp_scoreboard;
		alpha_t  alpha;
		sym_t    text[MAX_LEN_DEF + 1];
		int      n;
		bit      built;
		int      order[MAX_LEN_DEF + 1];
		int      lcp_at[MAX_LEN_DEF + 1];
		result_t owed[$];
		int      fails;
		int      shown;

		function new();
			alpha = ALPHA_RESET;
			n = 0;
			built = 0;
			fails = 0;
			shown = 0;
		endfunction

		// The sentinel is unique and smallest, so the scan always stops.
		function bit suffix_less(int a, int b);
			int k;
			k = 0;
			while (text[a + k] == text[b + k])
				k++;
			return text[a + k] < text[b + k];
		endfunction

		function void sort_text();
			int i, j, cur, h, a, b;
			text[n] = '0;
			for (i = 0; i <= n; i++)
				order[i] = i;
			for (i = 1; i <= n; i++) begin
				cur = order[i];
				j = i - 1;
				while (j >= 0 && suffix_less(cur, order[j])) begin
					order[j + 1] = order[j];
					j--;
				end
				order[j + 1] = cur;
			end
			lcp_at[0] = 0;
			for (i = 1; i <= n; i++) begin
				a = order[i];
				b = order[i - 1];
				h = 0;
				while (a + h < n && b + h < n && text[a + h] == text[b + h])
					h++;
				lcp_at[i] = h;
			end
			built = 1;
		endfunction

		function void note(request_t r);
			result_t e;
			e = '0;
			e.kind = KIND_ERROR;
			case (r.func)
				FUNC_LOAD: begin
					if (built || n >= MAX_LEN_DEF || r.symbol == '0 ||
							{1'b0, r.symbol} >= alpha) begin
						owed = {owed, e};
					end else begin
						text[n] = r.symbol;
						n++;
						if (r.last) begin
							sort_text();
							e.kind = KIND_DONE;
							e.length = len_t'(n);
							owed = {owed, e};
						end
					end
				end
				FUNC_READ: begin
					if (!built || r.rank < 1 || r.rank > n) begin
						owed = {owed, e};
					end else begin
						e.kind = KIND_READ;
						e.suffix_pos = pos_t'(order[r.rank]);
						e.lcp = pos_t'(lcp_at[r.rank]);
						e.length = len_t'(n);
						owed = {owed, e};
					end
				end
				FUNC_CLEAR: begin
					n = 0;
					built = 0;
				end
				default: owed = {owed, e};
			endcase
		endfunction

		function void check(result_t got);
			result_t e;
			if (owed.size() == 0) begin
				fails++;
				if (shown < 10)
					$display("unexpected result: kind %0d pos %0d lcp %0d len %0d",
						got.kind, got.suffix_pos, got.lcp, got.length);
				shown++;
				return;
			end
			e = owed.pop_front();
			if (e.kind != got.kind || e.suffix_pos != got.suffix_pos ||
					e.lcp != got.lcp || e.length != got.length) begin
				fails++;
				if (shown < 10)
					$display("mismatch: exp kind %0d pos %0d lcp %0d len %0d, got kind %0d pos %0d lcp %0d len %0d",
						e.kind, e.suffix_pos, e.lcp, e.length,
						got.kind, got.suffix_pos, got.lcp, got.length);
				shown++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   idle_cycles;
	int   sent;

	sal_cfg_if cfg_if ();
	sal_req_if req_if ();
	sal_rsp_if rsp_if ();

	lcp_scoreboard sb;

	suffix_array_lcp_builder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog: end the run when nothing moves on any channel for too long.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("suffix_array_lcp_builder regression: fail");
			$finish;
		end
	end

	// Result side: draw a stall before each result, then check it on accept.
	initial begin : result_sink
		int gap;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = $urandom_range(0, 3);
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid)
				@(posedge clk);
			sb.check({rsp_if.kind, rsp_if.suffix_pos, rsp_if.lcp, rsp_if.length});
		end
	end

	// Hold the request until the block takes it; note it in the scoreboard.
	task automatic send_request(func_t f, sym_t s, logic l, rank_t r);
		int gap;
		request_t item;
		item = '{func: f, symbol: s, last: l, rank: r};
		@(negedge clk);
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid  <= 1'b1;
		req_if.func   <= f;
		req_if.symbol <= s;
		req_if.last   <= l;
		req_if.rank   <= r;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note(item);
		sent++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		req_if.valid <= 1'b0;
	endtask

	// Wait until every owed result has come, plus a margin for silent requests.
	task automatic wait_drained();
		drop_valid();
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_alphabet(alpha_t v);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		sb.alpha = v;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic sym_t legal_symbol();
		int lim;
		lim = (sb.alpha > ALPHA_CAP) ? 256 : int'(sb.alpha);
		return sym_t'($urandom_range(1, lim - 1));
	endfunction

	function automatic sym_t illegal_symbol();
		if (sb.alpha <= 255 && $urandom_range(0, 1))
			return sym_t'($urandom_range(sb.alpha, 255));
		return '0;
	endfunction

	// Mostly whole texts with reads after the build; the rest noise.
	task automatic run_random(int quota);
		int stop, len, i, reads;
		rank_t r;
		sym_t s;
		stop = sent + quota;
		while (sent < stop) begin
			if ($urandom_range(0, 9) == 0) begin
				send_request(func_t'($urandom_range(0, 3)), sym_t'($urandom_range(0, 255)),
					logic'($urandom_range(0, 1)), rank_t'($urandom_range(0, 8191)));
			end else begin
				send_request(FUNC_CLEAR, sym_t'($urandom), logic'($urandom),
					rank_t'($urandom));
				len = ($urandom_range(0, 29) == 0) ? $urandom_range(30, 200)
					: $urandom_range(1, 24);
				for (i = 0; i < len; i++) begin
					s = ($urandom_range(0, 19) == 0) ? illegal_symbol() : legal_symbol();
					send_request(FUNC_LOAD, s, logic'(i == len - 1), rank_t'($urandom));
				end
				if (!sb.built)
					send_request(FUNC_LOAD, legal_symbol(), 1'b1, rank_t'($urandom));
				reads = $urandom_range(1, 8);
				for (i = 0; i < reads; i++) begin
					case ($urandom_range(0, 9))
						0: r = '0;
						1: r = rank_t'(sb.n + 1);
						2: r = rank_t'($urandom_range(0, 8191));
						default: r = rank_t'($urandom_range(1, sb.n));
					endcase
					send_request(FUNC_READ, sym_t'($urandom), logic'($urandom), r);
				end
				if ($urandom_range(0, 7) == 0)
					send_request(FUNC_LOAD, legal_symbol(), logic'($urandom), '0);
			end
		end
	endtask

	initial begin : stimulus
		int i;
		alpha_t settings[6];
		sb = new();
		idle_cycles = 0;
		sent = 0;
		req_if.valid = 1'b0;
		req_if.func = FUNC_CLEAR;
		req_if.symbol = '0;
		req_if.last = 1'b0;
		req_if.rank = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = ALPHA_RESET;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: errors before any build, bad symbols, a short build and reads.
		send_request(FUNC_READ, '0, 1'b0, 13'd1);
		send_request(func_t'(3), 8'hFF, 1'b1, 13'h1FFF);
		send_request(FUNC_LOAD, 8'd0, 1'b1, '0);
		send_request(FUNC_LOAD, 8'd32, 1'b0, '0);
		send_request(FUNC_LOAD, 8'd31, 1'b0, '0);
		send_request(FUNC_LOAD, 8'd1, 1'b0, '0);
		send_request(FUNC_LOAD, 8'd255, 1'b1, '0);
		send_request(FUNC_LOAD, 8'd31, 1'b0, '0);
		send_request(FUNC_LOAD, 8'd1, 1'b1, '0);
		for (i = 0; i <= 5; i++)
			send_request(FUNC_READ, '0, 1'b0, rank_t'(i));
		send_request(FUNC_READ, '0, 1'b0, 13'h1FFF);
		send_request(FUNC_LOAD, 8'd1, 1'b0, '0);
		send_request(FUNC_CLEAR, '0, 1'b0, '0);
		send_request(FUNC_READ, '0, 1'b0, 13'd1);
		send_request(FUNC_LOAD, 8'd7, 1'b1, '0);
		send_request(FUNC_READ, '0, 1'b0, 13'd1);
		send_request(FUNC_CLEAR, '0, 1'b0, '0);
		wait_drained();

		// Random phases across alphabet settings, extremes included.
		settings = '{9'd2, 9'd256, 9'd300, 9'd511, 9'd32, alpha_t'($urandom_range(3, 255))};
		for (i = 0; i < 6; i++) begin
			write_alphabet(settings[i]);
			run_random(RANDOM_ITEMS / 6);
			wait_drained();
		end

		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (sb.fails == 0 && sb.owed.size() == 0)
			$display("suffix_array_lcp_builder regression: pass");
		else
			$display("suffix_array_lcp_builder regression: fail");
		$finish;
	end
endmodule

// ===== suffix_array_lcp_builder.f =====
sv/sal_pkg.sv
sv/sal_req_if.sv
sv/sal_rsp_if.sv
sv/sal_cfg_if.sv
sv/sal_ram.sv
sv/sal_ctrl.sv
sv/sal_dp.sv
sv/suffix_array_lcp_builder.sv
sim/suffix_array_lcp_builder_test.sv
